// ===== rtl/core/gda_pkg.sv =====
// Shared types, constants and calendar tables for the date arithmetic core.
package gda_pkg;

	localparam int MAX_YEAR_DEF = 9999;
	localparam int YEAR_IN_W    = 14;
	localparam int YEAR_W_DEF   = 14;
	localparam int MONTH_W      = 4;
	localparam int DAY_W        = 5;
	localparam int OFF_W        = 23;
	localparam int ACC_W        = 25;
	localparam int CUM_W        = 9;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_DIFF  = 2'd1,
		KIND_WDAY  = 2'd2,
		KIND_CHECK = 2'd3
	} kind_t;

	typedef struct packed {
		logic clr;
		logic inc;
	} ycmd_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] n;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:                                        n = leap ? 5'd29 : 5'd28;
			default:                                     n = 5'd0;
		endcase
		return n;
	endfunction

	// days in the year before the first of month m
	function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [CUM_W-1:0] n;
		unique case (m)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		if (leap && m > 4'd2) begin
			n = n + 9'd1;
		end
		return n;
	endfunction

endpackage

// ===== rtl/core/gda_year_ctr.sv =====
// Year counter with running mod-4/100/400 residues that flags leap years.
module gda_year_ctr #(
	parameter int YEAR_W = gda_pkg::YEAR_W_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gda_pkg::ycmd_t    cmd,
	output logic [YEAR_W-1:0] year,
	output logic              leap
);

	logic [YEAR_W-1:0] year_q;
	logic [6:0]        c100_q;
	logic [8:0]        c400_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q <= YEAR_W'(1);
			c100_q <= 7'd1;
			c400_q <= 9'd1;
		end else if (cmd.clr) begin
			year_q <= YEAR_W'(1);
			c100_q <= 7'd1;
			c400_q <= 9'd1;
		end else if (cmd.inc) begin
			year_q <= year_q + YEAR_W'(1);
			c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
			c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
		end
	end

	assign year = year_q;
	assign leap = ((c400_q[1:0] == 2'd0) && (c100_q != 7'd0)) || (c400_q == 9'd0);

endmodule

// ===== rtl/core/gregorian_date_arithmetic_core.sv =====
// Top level: Gregorian date add, difference, weekday and validity core.
// One word per start pulse, taken when start is high and busy is low; busy stays
// high until the result, which is shown for a single cycle with done and cannot be
// held off. Every date is turned into a day count by walking years one per cycle
// through a shared accumulator: check and weekday walk the years of date A, and
// weekday then folds the day count mod 7; difference walks the years of A and B;
// add walks those of A and then of the result, capped at MAX_YEAR. An invalid date
// A ends the word after the year walk. The longest word is a difference between two
// dates in year 16383.
module gregorian_date_arithmetic_core #(
	parameter int MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       kind,
	input  logic [gda_pkg::YEAR_IN_W-1:0]    year_a,
	input  logic [gda_pkg::MONTH_W-1:0]      month_a,
	input  logic [gda_pkg::DAY_W-1:0]        day_a,
	input  logic [gda_pkg::YEAR_IN_W-1:0]    year_b,
	input  logic [gda_pkg::MONTH_W-1:0]      month_b,
	input  logic [gda_pkg::DAY_W-1:0]        day_b,
	input  logic signed [gda_pkg::OFF_W-1:0] offset,
	output logic                             done,
	output logic [gda_pkg::YEAR_IN_W-1:0]    res_year,
	output logic [gda_pkg::MONTH_W-1:0]      res_month,
	output logic [gda_pkg::DAY_W-1:0]        res_day,
	output logic signed [gda_pkg::OFF_W-1:0] day_difference,
	output logic [2:0]                       weekday,
	output logic                             date_valid,
	output logic                             range_error
);

	localparam int YSPAN  = (MAX_YEAR > 16383) ? MAX_YEAR : 16383;
	localparam int YEAR_W = $clog2(YSPAN + 1);
	localparam int ACC_W  = gda_pkg::ACC_W;
	localparam int OFF_W  = gda_pkg::OFF_W;
	localparam logic signed [ACC_W-1:0] DIFF_MAX = ACC_W'(4194303);
	localparam logic signed [ACC_W-1:0] DIFF_MIN = -ACC_W'(4194304);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SER_Y,
		ST_SER_M,
		ST_POST,
		ST_WALK_INIT,
		ST_WALK_Y,
		ST_WALK_M,
		ST_SAT,
		ST_MOD7
	} state_t;

	state_t                              state_q;
	gda_pkg::kind_t                      kind_q;
	logic [gda_pkg::YEAR_IN_W-1:0]       ya_q, yb_q;
	logic [gda_pkg::MONTH_W-1:0]         ma_q, mb_q, mc_q;
	logic [gda_pkg::DAY_W-1:0]           da_q, db_q;
	logic signed [OFF_W-1:0]             off_q;
	logic                                phase_b_q;
	logic signed [ACC_W-1:0]             acc_q, sera_q;
	logic                                done_q, valid_q, rerr_q;
	logic [gda_pkg::YEAR_IN_W-1:0]       ry_q;
	logic [gda_pkg::MONTH_W-1:0]         rm_q;
	logic [gda_pkg::DAY_W-1:0]           rd_q;
	logic signed [OFF_W-1:0]             diff_q;
	logic [2:0]                          wd_q;

	gda_pkg::ycmd_t                      ycmd;
	logic [YEAR_W-1:0]                   yc;
	logic                                leap;
	logic [gda_pkg::YEAR_IN_W-1:0]       tgt_y;
	logic [gda_pkg::MONTH_W-1:0]         tgt_m;
	logic [gda_pkg::DAY_W-1:0]           tgt_d;
	logic                                tgt_ok;
	logic signed [ACC_W-1:0]             ylen_x, mlen_x;
	logic                                y_fits, at_max, at_tgt;
	logic                                accept;

	assign accept = start && !busy;
	assign tgt_y  = phase_b_q ? yb_q : ya_q;
	assign tgt_m  = phase_b_q ? mb_q : ma_q;
	assign tgt_d  = phase_b_q ? db_q : da_q;
	assign tgt_ok = (tgt_m >= 4'd1) && (tgt_m <= 4'd12) && (tgt_d != '0)
		&& (tgt_d <= gda_pkg::month_len(tgt_m, leap));
	assign ylen_x = leap ? ACC_W'(366) : ACC_W'(365);
	assign mlen_x = ACC_W'(gda_pkg::month_len(mc_q, leap));
	assign y_fits = acc_q < ylen_x;
	assign at_max = yc == YEAR_W'(MAX_YEAR);
	assign at_tgt = yc == YEAR_W'(tgt_y);

	always_comb begin
		ycmd.clr = 1'b0;
		ycmd.inc = 1'b0;
		unique case (state_q)
			ST_IDLE:      ycmd.clr = accept;
			ST_SER_Y:     ycmd.inc = !at_tgt;
			ST_POST:      ycmd.clr = (kind_q == gda_pkg::KIND_DIFF) && !phase_b_q;
			ST_WALK_INIT: ycmd.clr = 1'b1;
			ST_WALK_Y:    ycmd.inc = !y_fits && !at_max;
			default:      ycmd.inc = 1'b0;
		endcase
	end

	gda_year_ctr #(
		.YEAR_W (YEAR_W)
	) u_year (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ycmd),
		.year   (yc),
		.leap   (leap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			kind_q    <= gda_pkg::KIND_ADD;
			ya_q      <= '0;
			ma_q      <= '0;
			da_q      <= '0;
			yb_q      <= '0;
			mb_q      <= '0;
			db_q      <= '0;
			mc_q      <= '0;
			off_q     <= '0;
			acc_q     <= '0;
			sera_q    <= '0;
			phase_b_q <= 1'b0;
			done_q    <= 1'b0;
			valid_q   <= 1'b0;
			rerr_q    <= 1'b0;
			ry_q      <= '0;
			rm_q      <= '0;
			rd_q      <= '0;
			diff_q    <= '0;
			wd_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q    <= gda_pkg::kind_t'(kind);
						ya_q      <= year_a;
						ma_q      <= month_a;
						da_q      <= day_a;
						yb_q      <= year_b;
						mb_q      <= month_b;
						db_q      <= day_b;
						off_q     <= offset;
						phase_b_q <= 1'b0;
						acc_q     <= '0;
						valid_q   <= 1'b0;
						rerr_q    <= 1'b0;
						ry_q      <= '0;
						rm_q      <= '0;
						rd_q      <= '0;
						diff_q    <= '0;
						wd_q      <= '0;
						if (year_a == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_SER_Y;
						end
					end
				end
				ST_SER_Y: begin
					if (at_tgt) begin
						state_q <= ST_SER_M;
					end else begin
						acc_q <= acc_q + ylen_x;
					end
				end
				ST_SER_M: begin
					if (!tgt_ok) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						acc_q   <= acc_q + ACC_W'(gda_pkg::cum_days(tgt_m, leap))
							+ ACC_W'(tgt_d) - ACC_W'(1);
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					unique case (kind_q)
						gda_pkg::KIND_CHECK: begin
							valid_q <= 1'b1;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						gda_pkg::KIND_ADD: begin
							valid_q <= 1'b1;
							acc_q   <= acc_q + {{(ACC_W-OFF_W){off_q[OFF_W-1]}}, off_q};
							state_q <= ST_WALK_INIT;
						end
						gda_pkg::KIND_DIFF: begin
							if (!phase_b_q) begin
								sera_q    <= acc_q;
								acc_q     <= '0;
								phase_b_q <= 1'b1;
								if (yb_q == '0) begin
									done_q  <= 1'b1;
									state_q <= ST_IDLE;
								end else begin
									state_q <= ST_SER_Y;
								end
							end else begin
								acc_q   <= sera_q - acc_q;
								state_q <= ST_SAT;
							end
						end
						gda_pkg::KIND_WDAY: begin
							state_q <= ST_MOD7;
						end
					endcase
				end
				ST_WALK_INIT: begin
					if (acc_q[ACC_W-1]) begin
						rerr_q  <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WALK_Y;
					end
				end
				ST_WALK_Y: begin
					if (y_fits) begin
						mc_q    <= 4'd1;
						state_q <= ST_WALK_M;
					end else if (at_max) begin
						rerr_q  <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						acc_q <= acc_q - ylen_x;
					end
				end
				ST_WALK_M: begin
					if (mc_q < 4'd12 && acc_q >= mlen_x) begin
						acc_q <= acc_q - mlen_x;
						mc_q  <= mc_q + 4'd1;
					end else begin
						ry_q    <= yc[gda_pkg::YEAR_IN_W-1:0];
						rm_q    <= mc_q;
						rd_q    <= acc_q[gda_pkg::DAY_W-1:0] + gda_pkg::DAY_W'(1);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_SAT: begin
					if (acc_q > DIFF_MAX) begin
						diff_q <= DIFF_MAX[OFF_W-1:0];
					end else if (acc_q < DIFF_MIN) begin
						diff_q <= DIFF_MIN[OFF_W-1:0];
					end else begin
						diff_q <= acc_q[OFF_W-1:0];
					end
					valid_q <= 1'b1;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_MOD7: begin
					// 8 = 1 mod 7: fold octal digits until one is left, 7 standing for 0
					if (acc_q[ACC_W-1:3] == '0) begin
						wd_q    <= (acc_q[2:0] == 3'd6) ? 3'd0
							: (acc_q[2:0] == 3'd7) ? 3'd1 : acc_q[2:0] + 3'd1;
						valid_q <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						acc_q <= ACC_W'(acc_q[ACC_W-1:3]) + ACC_W'(acc_q[2:0]);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy           = state_q != ST_IDLE;
	assign done           = done_q;
	assign res_year       = ry_q;
	assign res_month      = rm_q;
	assign res_day        = rd_q;
	assign day_difference = diff_q;
	assign weekday        = wd_q;
	assign date_valid     = valid_q;
	assign range_error    = rerr_q;

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && year_a != '0) |=> busy) else $error("accepted word not worked");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !date_valid) |-> (res_year == '0 && res_month == '0 && res_day == '0
		&& day_difference == '0 && weekday == '0 && !range_error))
		else $error("invalid date with nonzero result");
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && range_error) |-> (date_valid && res_year == '0 && res_month == '0
		&& res_day == '0)) else $error("range error with date");
	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> weekday <= 3'd6) else $error("weekday out of range");
`endif

endmodule
